// ===== rtl/core/atfsc_pkg.sv =====
// shared constants, tables and helper functions for the tilt filter / step counter
// no dependencies
package atfsc_pkg;

  localparam int CordicStepsDef = 16;
  localparam int FilterFracDef  = 16;
  localparam int AtanLen        = 25;
  localparam int AngLimit       = 46080;

  // register indexes
  localparam logic [1:0] RegWeight  = 2'd0;
  localparam logic [1:0] RegDead    = 2'd1;
  localparam logic [1:0] RegArm     = 2'd2;
  localparam logic [1:0] RegRelease = 2'd3;
  localparam int CfgIdxW = 2;

  // item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindClear  = 1'b1;

  // cordic work width: 17-bit operand scaled by 2^24 plus growth
  localparam int CordW = 44;
  // angle accumulator in 1/65536 degree
  localparam int ZW    = 26;

  // rounded atan table in 1/65536 degree
  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 26'd2949120;
      5'd1:  r = 26'd1740967;
      5'd2:  r = 26'd919879;
      5'd3:  r = 26'd466945;
      5'd4:  r = 26'd234379;
      5'd5:  r = 26'd117304;
      5'd6:  r = 26'd58666;
      5'd7:  r = 26'd29335;
      5'd8:  r = 26'd14668;
      5'd9:  r = 26'd7334;
      5'd10: r = 26'd3667;
      5'd11: r = 26'd1833;
      5'd12: r = 26'd917;
      5'd13: r = 26'd458;
      5'd14: r = 26'd229;
      5'd15: r = 26'd115;
      5'd16: r = 26'd57;
      5'd17: r = 26'd29;
      5'd18: r = 26'd14;
      5'd19: r = 26'd7;
      5'd20: r = 26'd4;
      5'd21: r = 26'd2;
      5'd22: r = 26'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp a wide signed angle to +-180 degree in 1/256 units
  function automatic logic signed [16:0] clamp_ang(input logic signed [47:0] v);
    logic signed [16:0] r;
    if (v > 48'sd46080) r = 17'sd46080;
    else if (v < -48'sd46080) r = -17'sd46080;
    else r = v[16:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/atfsc_cordic.sv =====
// iterative cordic vectoring unit: atan2(y, x) in 1/256 degree
// depends on atfsc_pkg
module atfsc_cordic #(
  parameter int CORDIC_STEPS = atfsc_pkg::CordicStepsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [16:0]  y_in,
  input  logic signed [16:0]  x_in,
  output logic                done,
  output logic signed [16:0]  angle
);
  import atfsc_pkg::*;

  localparam int Steps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

  logic signed [CordW-1:0] x_r, y_r;
  logic signed [ZW-1:0]    z_r;
  logic [4:0]              i_r;
  logic                    busy_r, done_r;
  logic signed [16:0]      angle_r;

  logic signed [CordW-1:0] xs, ys, xe, ye;
  logic signed [ZW-1:0]    a;
  logic signed [ZW-1:0]    zr;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign a  = atan_lut(i_r);
  assign zr = (z_r + ZW'(128)) >>> 8;
  assign xe = {{(CordW-41){x_in[16]}}, x_in, 24'd0};
  assign ye = {{(CordW-41){y_in[16]}}, y_in, 24'd0};

  // one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (x_in == 0 && y_in == 0) begin
          angle_r <= '0;
          done_r  <= 1'b1;
        end else if (x_in < 0) begin
          busy_r <= 1'b1;
          x_r <= -xe;
          y_r <= -ye;
          z_r <= (y_in >= 0) ? ZW'(180*65536) : -ZW'(180*65536);
        end else begin
          busy_r <= 1'b1;
          x_r <= xe;
          y_r <= ye;
          z_r <= '0;
        end
      end else if (busy_r) begin
        if (32'(i_r) == Steps) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          angle_r <= clamp_ang(48'(zr));
        end else begin
          if (y_r >= 0) begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + a;
          end else begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - a;
          end
          i_r <= i_r + 5'd1;
        end
      end
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("cordic restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> 32'(i_r) <= Steps) else $error("index overrun");
endmodule

// ===== rtl/core/atfsc_isqrt.sv =====
// bit-pair iterative integer square root of a 34-bit value
// depends on atfsc_pkg
module atfsc_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] value,
  output logic        done,
  output logic [15:0] root
);
  import atfsc_pkg::*;

  logic [35:0] v_r, res_r, bit_r;
  logic        busy_r, done_r;
  logic [35:0] trial;

  assign trial = res_r + bit_r;

  // one result bit per cycle; leading zero bits just shift out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= 36'(value);
        res_r  <= '0;
        bit_r  <= 36'(1) << 34;
      end else if (busy_r) begin
        if (bit_r == 0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (v_r >= trial) begin
            v_r   <= v_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[15:0];

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("isqrt restarted while busy");
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> res_r[35:16] == 0) else $error("root too wide");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
endmodule

// ===== rtl/core/accel_tilt_filter_step_counter.sv =====
// top level: tilt filter and step counter sequencer
// depends on atfsc_pkg, atfsc_cordic, atfsc_isqrt
//
// Usage: items enter on in_valid/in_ready with kind and three signed
// 16-bit axes; one result leaves on out_valid/out_ready per item.
// A sample runs roll cordic and pitch cordic in sequence on one shared
// cordic unit, accumulating the squares while the roll cordic runs, then
// the square root, then the filter step per angle, a multiply phase and
// an apply phase. in_ready rises in the same cycle as out_valid. A clear
// item resets count, magnitude and step flag and goes to the output.
// The block takes one item at a time; in_ready is high only when idle.
// Registers are written on cfg_valid/cfg_ready (always ready); indexes
// beyond the list are ignored. Synchronous active-low reset sets the
// registers to their defaults and clears filters, detector and count.
// A stalled receiver holds the result in the output register and the
// block waits before loading the next result until it is taken.
module accel_tilt_filter_step_counter #(
  parameter int CORDIC_STEPS     = atfsc_pkg::CordicStepsDef,
  parameter int FILTER_FRAC_BITS = atfsc_pkg::FilterFracDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic signed [15:0]          in_accel_x,
  input  logic signed [15:0]          in_accel_y,
  input  logic signed [15:0]          in_accel_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [16:0]          out_roll,
  output logic signed [16:0]          out_pitch,
  output logic [15:0]                 out_magnitude,
  output logic [15:0]                 out_steps,
  output logic                        out_step_seen,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [atfsc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0]                 cfg_data
);
  import atfsc_pkg::*;

  localparam int F  = FILTER_FRAC_BITS;
  localparam int SW = 18 + F;       // smoothed state width
  localparam int DW = SW + 1;       // difference width
  localparam int PW = DW + 17;      // product width

  typedef enum logic [3:0] {
    S_IDLE, S_ROLL, S_ROLL_W, S_PITCH, S_PITCH_W, S_SQRT, S_SQRT_W,
    S_FILT, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] weight_r, dead_r, arm_r, rel_r;
  logic signed [SW-1:0] roll_s_r, pitch_s_r;
  logic armed_r;
  logic [15:0] steps_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [16:0] raw_roll_r, raw_pitch_r;
  logic [15:0] mag_r;
  logic        seen_r;
  logic [33:0] sum_r;
  logic [1:0]  sq_r;
  logic        sel_r;   // filter pass: 0 roll, 1 pitch
  logic        ph_r;    // filter phase: 0 multiply, 1 apply

  // cordic and square root operands
  logic        c_start, c_done;
  logic signed [16:0] c_y, c_x, c_ang;
  logic        q_start, q_done;
  logic [15:0] q_root;

  assign c_x = -17'(az_r);
  assign c_y = (state_r == S_ROLL) ? 17'(ay_r) : -17'(ax_r);
  assign c_start = (state_r == S_ROLL) || (state_r == S_PITCH);
  assign q_start = (state_r == S_SQRT);

  atfsc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(c_start), .y_in(c_y), .x_in(c_x),
    .done(c_done), .angle(c_ang));

  atfsc_isqrt u_isqrt (
    .clk, .rst_n, .start(q_start), .value(sum_r), .done(q_done), .root(q_root));

  // squared axis through one 16x16 multiplier, one per cycle
  logic signed [15:0] sq_op;
  logic [31:0] sq_val;
  always_comb begin
    unique case (sq_r)
      2'd0: sq_op = ax_r;
      2'd1: sq_op = ay_r;
      default: sq_op = az_r;
    endcase
  end
  assign sq_val = 32'(sq_op * sq_op);

  // shared filter datapath: weighted difference, then update and dead band
  logic signed [SW-1:0] s_cur, s_new;
  logic signed [16:0]   raw_cur;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod, prod_r;
  logic signed [SW-1:0] s_abs;
  assign s_cur   = sel_r ? pitch_s_r : roll_s_r;
  assign raw_cur = sel_r ? raw_pitch_r : raw_roll_r;
  assign diff = (DW'(raw_cur) <<< F) - DW'(s_cur);
  assign prod = PW'(diff) * $signed({1'b0, weight_r});
  always_comb begin
    s_new = s_cur + SW'((prod_r + PW'(32768)) >>> 16);
    s_abs = (s_new < 0) ? -s_new : s_new;
    if (s_abs < (SW'(dead_r) << F)) s_new = '0;
  end

  function automatic logic signed [16:0] ang_out(input logic signed [SW-1:0] s);
    logic signed [SW:0] t;
    t = (SW+1)'(s) + ((SW+1)'(1) <<< (F-1));
    return clamp_ang(48'(t >>> F));
  endfunction

  logic [16:0] mag_cmp;
  assign mag_cmp = 17'(q_root);

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      weight_r  <= 16'd3277;
      dead_r    <= 16'd128;
      arm_r     <= 16'd10650;
      rel_r     <= 16'd7373;
      roll_s_r  <= '0;
      pitch_s_r <= '0;
      armed_r   <= 1'b0;
      steps_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegWeight:  weight_r <= cfg_data;
          RegDead:    dead_r   <= cfg_data;
          RegArm:     arm_r    <= cfg_data;
          RegRelease: rel_r    <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state_r != S_OUT) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          ax_r <= in_accel_x; ay_r <= in_accel_y; az_r <= in_accel_z;
          if (in_kind == KindClear) begin
            steps_r <= '0;
            mag_r   <= '0;
            seen_r  <= 1'b0;
            state_r <= S_OUT;
          end else begin
            sum_r <= '0;
            sq_r  <= '0;
            state_r <= S_ROLL;
          end
        end
        S_ROLL: begin
          // start the cordic; squares accumulate in the wait state while it runs
          state_r <= S_ROLL_W;
        end
        S_ROLL_W: begin
          if (sq_r != 2'd3) begin
            sum_r <= sum_r + 34'(sq_val);
            sq_r  <= sq_r + 2'd1;
          end
          if (c_done) begin
            raw_roll_r <= c_ang;
            state_r <= S_PITCH;
          end
        end
        S_PITCH: state_r <= S_PITCH_W;
        S_PITCH_W: if (c_done) begin
          raw_pitch_r <= c_ang;
          state_r <= S_SQRT;
        end
        S_SQRT: state_r <= S_SQRT_W;
        S_SQRT_W: if (q_done) begin
          mag_r  <= q_root;
          seen_r <= 1'b0;
          if ((mag_cmp > 17'(arm_r)) || armed_r) begin
            if (q_root < rel_r) begin
              armed_r <= 1'b0;
              steps_r <= steps_r + 16'd1;
              seen_r  <= 1'b1;
            end else begin
              armed_r <= 1'b1;
            end
          end
          sel_r   <= 1'b0;
          ph_r    <= 1'b0;
          state_r <= S_FILT;
        end
        S_FILT: begin
          if (!ph_r) begin
            // register the weighted difference, apply it next cycle
            prod_r <= prod;
            ph_r   <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (sel_r) begin
              pitch_s_r <= s_new;
              state_r   <= S_OUT;
            end else begin
              roll_s_r <= s_new;
              sel_r    <= 1'b1;
            end
          end
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_roll      <= ang_out(roll_s_r);
          out_pitch     <= ang_out(pitch_s_r);
          out_magnitude <= mag_r;
          out_steps     <= steps_r;
          out_step_seen <= seen_r;
          out_valid     <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE) else $error("item lost");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT)) else $error("stray result");
  a_step_seen_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_seen) |-> out_steps == steps_r || state_r != S_IDLE)
    else $error("step count mismatch");
  a_mag_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_done |-> state_r == S_SQRT_W) else $error("sqrt out of turn");
endmodule
